>>> rtl/eas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator package
// Widths, register indexes, reset values, the shared multiply-accumulate
// request and the rounding helpers used by the estimator.
// ----------------------------------------------------------------------------
package eas_pkg;

   // Shared multiplier operand, product and accumulator widths.
   localparam int A_W    = 26;
   localparam int B_W    = 32;
   localparam int PROD_W = A_W + B_W;
   localparam int ACC_W  = 73;
   localparam int SPLIT  = 20;

   // Field widths.
   localparam int POS_W   = 16;
   localparam int RAW_W   = 17;
   localparam int MECH_W  = 32;
   localparam int ELEC_W  = 39;
   localparam int DIFF_W  = 40;
   localparam int RSPD_W  = 36;
   localparam int SPEED_W = 26;
   localparam int PPC_W   = 7;
   localparam int FW_W    = 25;
   localparam int DIR_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLE_PAIRS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_KEEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TAKE = 3'd5;

   // Register reset values.
   localparam logic [POS_W-1:0]         RST_CAL_OFFSET  = 16'd0;
   localparam logic signed [B_W-1:0]    RST_COUNT_SCALE = 32'sd262144;
   localparam logic [PPC_W-1:0]         RST_POLE_PAIRS  = 7'd4;
   localparam logic signed [B_W-1:0]    RST_SPEED_GAIN  = 32'sd16777216;
   localparam logic [FW_W-1:0]          RST_FILTER_KEEP = 25'd15099494;
   localparam logic [FW_W-1:0]          RST_FILTER_TAKE = 25'd1677722;

   // Magnitude band of the mechanical angle in which speed is measured.
   localparam logic [MECH_W:0] BAND_LOW  = 33'd838861;
   localparam logic [MECH_W:0] BAND_HIGH = 33'd15938355;

   // Rounded results before saturation.
   localparam int MRND_W = PROD_W - 6;
   localparam int QRND_W = ACC_W - 24;

   localparam logic signed [MRND_W-1:0] MECH_MAX  = 52'sd2147483647;
   localparam logic signed [MRND_W-1:0] MECH_MIN  = -52'sd2147483648;
   localparam logic signed [QRND_W-1:0] RSPD_MAX  = 49'sd34359738367;
   localparam logic signed [QRND_W-1:0] RSPD_MIN  = -49'sd34359738367;
   localparam logic signed [QRND_W-1:0] SPEED_MAX = 49'sd16777216;
   localparam logic signed [QRND_W-1:0] SPEED_MIN = -49'sd16777216;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SHL_ADD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      acc_op_type            op;
      logic signed [A_W-1:0] a;
      logic signed [B_W-1:0] b;
   } mac_req_type;

   // Divide by 64, round to nearest with ties away from zero, saturate to 32 bits.
   function automatic logic signed [MECH_W-1:0] mech_round_sat(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      logic signed [MRND_W-1:0] r;
      t = p + (p[PROD_W-1] ? PROD_W'(31) : PROD_W'(32));
      r = t[PROD_W-1:6];
      if (r > MECH_MAX) begin
         return MECH_MAX[MECH_W-1:0];
      end else if (r < MECH_MIN) begin
         return MECH_MIN[MECH_W-1:0];
      end
      return r[MECH_W-1:0];
   endfunction

   // Divide by 2^24, round to nearest with ties away from zero.
   function automatic logic signed [QRND_W-1:0] q24_round(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + (v[ACC_W-1] ? ACC_W'(8388607) : ACC_W'(8388608));
      return t[ACC_W-1:24];
   endfunction

endpackage

`default_nettype wire

>>> rtl/eas_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Estimator channels
// Sample, result and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface eas_req_if;
   import eas_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [POS_W-1:0]        position_count;
   logic signed [DIR_W-1:0] direction;
   modport source (output valid, position_count, direction, input ready);
   modport sink   (input valid, position_count, direction, output ready);
endinterface

interface eas_rsp_if;
   import eas_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [RAW_W-1:0]          raw_angle;
   logic signed [MECH_W-1:0]  mech_angle;
   logic signed [ELEC_W-1:0]  elec_angle;
   logic signed [SPEED_W-1:0] speed;
   logic signed [DIR_W-1:0]   direction_out;
   modport source (output valid, raw_angle, mech_angle, elec_angle, speed,
                   direction_out, input ready);
   modport sink   (input valid, raw_angle, mech_angle, elec_angle, speed,
                   direction_out, output ready);
endinterface

interface eas_csr_if;
   import eas_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/eas_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registers a signed 26 by 32 bit product each cycle; the accumulator holds,
// loads, adds, or shifts by the split width and adds the previous product.
// ----------------------------------------------------------------------------
module eas_mac (
   input  wire logic                              clock,
   input  wire eas_pkg::mac_req_type              req,
   output logic signed [eas_pkg::PROD_W-1:0]      prod,
   output logic signed [eas_pkg::ACC_W-1:0]       acc
);
   import eas_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_in  = $signed(req.a) * $signed(req.b);
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (req.op)
         ACC_LOAD:    acc_in = prod_ext;
         ACC_SHL_ADD: acc_in = (acc_ff <<< SPLIT) + prod_ext;
         ACC_ADD:     acc_in = acc_ff + prod_ext;
         default:     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

>>> rtl/encoder_angle_speed_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator
// Per sample: offset count, mechanical and electrical angle, band-gated raw
// speed and a clamped first-order low-pass, all on one shared multiplier.
// ----------------------------------------------------------------------------
//   Channel   Modport  Word
//   req_bus   sink     position_count, direction
//   rsp_bus   source   raw_angle, mech_angle, elec_angle, speed, direction_out
//   csr_bus   sink     index, data (always ready)
//
// A sample steps through the sequencer states from acceptance to result and
// skips the difference and raw-speed steps outside the speed band; inside it,
// seven sequential multiplies share the single 26x32 multiplier and accumulator.
// Reset is synchronous, restores the config registers and clears the filter state.
// A finished word waits in the output register; the next sample is accepted
// meanwhile and stalls at its last step until the pending word is taken.
// ----------------------------------------------------------------------------
module encoder_angle_speed_estimator (
   input wire logic  clock,
   input wire logic  reset,
   eas_req_if.sink   req_bus,
   eas_rsp_if.source rsp_bus,
   eas_csr_if.sink   csr_bus
);
   import eas_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_M_MECH = 14'b00000000000010,
      ST_A_MECH = 14'b00000000000100,
      ST_M_ELEC = 14'b00000000001000,
      ST_A_ELEC = 14'b00000000010000,
      ST_M_DHI  = 14'b00000000100000,
      ST_M_DLO  = 14'b00000001000000,
      ST_A_DLO  = 14'b00000010000000,
      ST_R_SPD  = 14'b00000100000000,
      ST_M_FHI  = 14'b00001000000000,
      ST_M_FLO  = 14'b00010000000000,
      ST_M_FKP  = 14'b00100000000000,
      ST_A_FKP  = 14'b01000000000000,
      ST_R_FLT  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [POS_W-1:0]      cal_offset_ff,  cal_offset_in;
   logic signed [B_W-1:0] count_scale_ff, count_scale_in;
   logic [PPC_W-1:0]      pole_pairs_ff,  pole_pairs_in;
   logic signed [B_W-1:0] speed_gain_ff,  speed_gain_in;
   logic [FW_W-1:0]       filter_keep_ff, filter_keep_in;
   logic [FW_W-1:0]       filter_take_ff, filter_take_in;

   // Filter state.
   logic signed [ELEC_W-1:0]  last_elec_ff,  last_elec_in;
   logic signed [SPEED_W-1:0] last_speed_ff, last_speed_in;

   // Working registers.
   logic [RAW_W-1:0]          raw_ff,    raw_in;
   logic signed [DIR_W-1:0]   dir_ff,    dir_in;
   logic signed [MECH_W-1:0]  mech_ff,   mech_in;
   logic signed [ELEC_W-1:0]  elec_ff,   elec_in;
   logic signed [DIFF_W-1:0]  diff_ff,   diff_in;
   logic signed [RSPD_W-1:0]  rspeed_ff, rspeed_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]          out_raw_ff,   out_raw_in;
   logic signed [MECH_W-1:0]  out_mech_ff,  out_mech_in;
   logic signed [ELEC_W-1:0]  out_elec_ff,  out_elec_in;
   logic signed [SPEED_W-1:0] out_speed_ff, out_speed_in;
   logic signed [DIR_W-1:0]   out_dir_ff,   out_dir_in;

   mac_req_type               mac_req;
   logic signed [PROD_W-1:0]  mac_prod;
   logic signed [ACC_W-1:0]   mac_acc;

   logic                      req_take;
   logic                      finish;
   logic [MECH_W:0]           mech_mag;
   logic                      in_band;
   logic signed [QRND_W-1:0]  acc_rnd;
   logic signed [SPEED_W-1:0] speed_new;

   eas_mac u_mac (
      .clock (clock),
      .req   (mac_req),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // The result leaves only once the previous word has gone.
   assign finish = (state_ff == ST_R_FLT) && (!rsp_valid_ff || rsp_bus.ready);

   assign mech_mag = mech_ff[MECH_W-1] ? -{mech_ff[MECH_W-1], mech_ff}
                                       : {mech_ff[MECH_W-1], mech_ff};
   assign in_band  = (mech_mag >= BAND_LOW) && (mech_mag <= BAND_HIGH);
   assign acc_rnd  = q24_round(mac_acc);

   always_comb begin
      if (acc_rnd > SPEED_MAX) begin
         speed_new = SPEED_MAX[SPEED_W-1:0];
      end else if (acc_rnd < SPEED_MIN) begin
         speed_new = SPEED_MIN[SPEED_W-1:0];
      end else begin
         speed_new = acc_rnd[SPEED_W-1:0];
      end
   end

   // Multiplier operands and accumulator operation for each step.
   always_comb begin
      mac_req.op = ACC_HOLD;
      mac_req.a  = '0;
      mac_req.b  = '0;
      unique case (state_ff)
         ST_M_MECH: begin
            mac_req.a = $signed({{(A_W-RAW_W){1'b0}}, raw_ff});
            mac_req.b = count_scale_ff;
         end
         ST_M_ELEC: begin
            mac_req.a = $signed({{(A_W-PPC_W){1'b0}}, pole_pairs_ff});
            mac_req.b = mech_ff;
         end
         ST_M_DHI: begin
            mac_req.a = $signed({{(A_W-(DIFF_W-SPLIT)){diff_ff[DIFF_W-1]}},
                                 diff_ff[DIFF_W-1:SPLIT]});
            mac_req.b = speed_gain_ff;
         end
         ST_M_DLO: begin
            mac_req.op = ACC_LOAD;
            mac_req.a  = $signed({{(A_W-SPLIT){1'b0}}, diff_ff[SPLIT-1:0]});
            mac_req.b  = speed_gain_ff;
         end
         ST_A_DLO: begin
            mac_req.op = ACC_SHL_ADD;
         end
         ST_M_FHI: begin
            mac_req.a = $signed({{(A_W-FW_W){1'b0}}, filter_take_ff});
            mac_req.b = $signed({{(B_W-(RSPD_W-SPLIT)){rspeed_ff[RSPD_W-1]}},
                                 rspeed_ff[RSPD_W-1:SPLIT]});
         end
         ST_M_FLO: begin
            mac_req.op = ACC_LOAD;
            mac_req.a  = $signed({{(A_W-FW_W){1'b0}}, filter_take_ff});
            mac_req.b  = $signed({{(B_W-SPLIT){1'b0}}, rspeed_ff[SPLIT-1:0]});
         end
         ST_M_FKP: begin
            mac_req.op = ACC_SHL_ADD;
            mac_req.a  = $signed({{(A_W-FW_W){1'b0}}, filter_keep_ff});
            mac_req.b  = B_W'(last_speed_ff);
         end
         ST_A_FKP: begin
            mac_req.op = ACC_ADD;
         end
         default: begin
            mac_req.op = ACC_HOLD;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_M_MECH;
         ST_M_MECH: state_in = ST_A_MECH;
         ST_A_MECH: state_in = ST_M_ELEC;
         ST_M_ELEC: state_in = ST_A_ELEC;
         ST_A_ELEC: state_in = in_band ? ST_M_DHI : ST_M_FHI;
         ST_M_DHI:  state_in = ST_M_DLO;
         ST_M_DLO:  state_in = ST_A_DLO;
         ST_A_DLO:  state_in = ST_R_SPD;
         ST_R_SPD:  state_in = ST_M_FHI;
         ST_M_FHI:  state_in = ST_M_FLO;
         ST_M_FLO:  state_in = ST_M_FKP;
         ST_M_FKP:  state_in = ST_A_FKP;
         ST_A_FKP:  state_in = ST_R_FLT;
         ST_R_FLT:  if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath registers.
   always_comb begin
      raw_in    = raw_ff;
      dir_in    = dir_ff;
      mech_in   = mech_ff;
      elec_in   = elec_ff;
      diff_in   = diff_ff;
      rspeed_in = rspeed_ff;
      if (req_take) begin
         raw_in = {1'b0, req_bus.position_count} + {1'b0, cal_offset_ff};
         dir_in = req_bus.direction;
      end
      if (state_ff == ST_A_MECH) begin
         mech_in = mech_round_sat(mac_prod);
      end
      if (state_ff == ST_A_ELEC) begin
         // The product of pole pairs and a 32-bit angle always fits 39 bits.
         elec_in = mac_prod[ELEC_W-1:0];
         diff_in = DIFF_W'($signed(mac_prod[ELEC_W-1:0])) - DIFF_W'(last_elec_ff);
         // Outside the band the previous speed stands in for the raw speed.
         rspeed_in = RSPD_W'(last_speed_ff);
      end
      if (state_ff == ST_R_SPD) begin
         if (acc_rnd > RSPD_MAX) begin
            rspeed_in = RSPD_MAX[RSPD_W-1:0];
         end else if (acc_rnd < RSPD_MIN) begin
            rspeed_in = RSPD_MIN[RSPD_W-1:0];
         end else begin
            rspeed_in = acc_rnd[RSPD_W-1:0];
         end
      end
   end

   // Filter state and output register.
   always_comb begin
      last_elec_in  = last_elec_ff;
      last_speed_in = last_speed_ff;
      out_raw_in    = out_raw_ff;
      out_mech_in   = out_mech_ff;
      out_elec_in   = out_elec_ff;
      out_speed_in  = out_speed_ff;
      out_dir_in    = out_dir_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      if (finish) begin
         last_elec_in  = elec_ff;
         last_speed_in = speed_new;
         out_raw_in    = raw_ff;
         out_mech_in   = mech_ff;
         out_elec_in   = elec_ff;
         out_speed_in  = speed_new;
         out_dir_in    = dir_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   // Register writes.
   always_comb begin
      cal_offset_in  = cal_offset_ff;
      count_scale_in = count_scale_ff;
      pole_pairs_in  = pole_pairs_ff;
      speed_gain_in  = speed_gain_ff;
      filter_keep_in = filter_keep_ff;
      filter_take_in = filter_take_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CAL_OFFSET:  cal_offset_in  = csr_bus.data[POS_W-1:0];
            CSR_COUNT_SCALE: count_scale_in = csr_bus.data;
            CSR_POLE_PAIRS:  pole_pairs_in  = csr_bus.data[PPC_W-1:0];
            CSR_SPEED_GAIN:  speed_gain_in  = csr_bus.data;
            CSR_FILTER_KEEP: filter_keep_in = csr_bus.data[FW_W-1:0];
            CSR_FILTER_TAKE: filter_take_in = csr_bus.data[FW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_elec_ff   <= '0;
         last_speed_ff  <= '0;
         cal_offset_ff  <= RST_CAL_OFFSET;
         count_scale_ff <= RST_COUNT_SCALE;
         pole_pairs_ff  <= RST_POLE_PAIRS;
         speed_gain_ff  <= RST_SPEED_GAIN;
         filter_keep_ff <= RST_FILTER_KEEP;
         filter_take_ff <= RST_FILTER_TAKE;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_elec_ff   <= last_elec_in;
         last_speed_ff  <= last_speed_in;
         cal_offset_ff  <= cal_offset_in;
         count_scale_ff <= count_scale_in;
         pole_pairs_ff  <= pole_pairs_in;
         speed_gain_ff  <= speed_gain_in;
         filter_keep_ff <= filter_keep_in;
         filter_take_ff <= filter_take_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      dir_ff       <= dir_in;
      mech_ff      <= mech_in;
      elec_ff      <= elec_in;
      diff_ff      <= diff_in;
      rspeed_ff    <= rspeed_in;
      out_raw_ff   <= out_raw_in;
      out_mech_ff  <= out_mech_in;
      out_elec_ff  <= out_elec_in;
      out_speed_ff <= out_speed_in;
      out_dir_ff   <= out_dir_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.raw_angle     = out_raw_ff;
   assign rsp_bus.mech_angle    = out_mech_ff;
   assign rsp_bus.elec_angle    = out_elec_ff;
   assign rsp_bus.speed         = out_speed_ff;
   assign rsp_bus.direction_out = out_dir_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb_encoder_angle_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and speed estimator testbench
// Streams encoder samples through the estimator under random register
// settings and random flow control on both channels. Each sample is run
// through a local fixed-point predictor when it is accepted, and every
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_encoder_angle_speed_estimator;
   import eas_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_PRINTS  = 40;

   localparam logic signed [127:0] LIM_MECH_HI = 128'sd2147483647;
   localparam logic signed [127:0] LIM_MECH_LO = -128'sd2147483648;
   localparam logic signed [127:0] LIM_ELEC_HI = 128'sd274877906943;
   localparam logic signed [127:0] LIM_ELEC_LO = -128'sd274877906944;
   localparam logic signed [127:0] LIM_RSPD    = 128'sd34359738367;
   localparam logic signed [127:0] LIM_ONE     = 128'sd16777216;

   localparam logic signed [DIR_W-1:0] DIR_ZERO = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_ODD  = 2'sb10;
   localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [CSR_DATA_W-1:0] S32_MAX         = 32'h7FFF_FFFF;
   localparam logic [CSR_DATA_W-1:0] S32_MIN         = 32'h8000_0000;
   localparam logic [CSR_DATA_W-1:0] ALL_ONES        = 32'hFFFF_FFFF;
   localparam logic [CSR_DATA_W-1:0] HALF_REV_SCALE  = 32'h2000_0000;
   localparam logic [CSR_DATA_W-1:0] NHALF_REV_SCALE = 32'hE000_0000;

   typedef struct {
      logic [RAW_W-1:0]          raw_angle;
      logic signed [MECH_W-1:0]  mech_angle;
      logic signed [ELEC_W-1:0]  elec_angle;
      logic signed [SPEED_W-1:0] speed;
      logic signed [DIR_W-1:0]   direction_out;
   } angle_word_type;

   logic clock;
   logic reset;

   eas_req_if req_bus ();
   eas_rsp_if rsp_bus ();
   eas_csr_if csr_bus ();

   encoder_angle_speed_estimator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor copy of the registers and the filter state.
   logic [POS_W-1:0]          m_cal_offset;
   logic signed [B_W-1:0]     m_count_scale;
   logic [PPC_W-1:0]          m_pole_pairs;
   logic signed [B_W-1:0]     m_speed_gain;
   logic [FW_W-1:0]           m_filter_keep;
   logic [FW_W-1:0]           m_filter_take;
   logic signed [ELEC_W-1:0]  m_last_elec;
   logic signed [SPEED_W-1:0] m_last_speed;

   angle_word_type pending_angles[$];
   int error_count;
   bit no_idle;
   int stall_asks;
   int stall_seen;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [127:0] shift_round(input logic signed [127:0] v,
                                                       input int sh);
      logic [127:0] m;
      m = v[127] ? -v : v;
      m = (m + (128'd1 << (sh - 1))) >> sh;
      return v[127] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [127:0] clamp_q(input logic signed [127:0] v,
                                                   input logic signed [127:0] lo,
                                                   input logic signed [127:0] hi);
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic angle_word_type estimate_angles(input logic [POS_W-1:0] pos,
                                                      input logic signed [DIR_W-1:0] dir);
      angle_word_type word;
      logic [RAW_W-1:0] raw;
      logic signed [127:0] raw_w, scale_w, pole_w, gain_w, keep_w, take_w;
      logic signed [127:0] prev_elec, prev_speed, mech, elec, rspd, spd;
      logic [127:0] mech_mag;
      raw = RAW_W'(pos) + RAW_W'(m_cal_offset);
      raw_w = raw;
      scale_w = m_count_scale;
      pole_w = m_pole_pairs;
      gain_w = m_speed_gain;
      keep_w = m_filter_keep;
      take_w = m_filter_take;
      prev_elec = m_last_elec;
      prev_speed = m_last_speed;
      mech = clamp_q(shift_round(raw_w * scale_w, 6), LIM_MECH_LO, LIM_MECH_HI);
      elec = clamp_q(pole_w * mech, LIM_ELEC_LO, LIM_ELEC_HI);
      mech_mag = mech[127] ? -mech : mech;
      // Near the index the angle change is meaningless, so the old speed is reused.
      if (mech_mag >= BAND_LOW && mech_mag <= BAND_HIGH) begin
         rspd = clamp_q(shift_round((elec - prev_elec) * gain_w, 24), -LIM_RSPD, LIM_RSPD);
      end else begin
         rspd = prev_speed;
      end
      spd = clamp_q(shift_round(keep_w * prev_speed + take_w * rspd, 24), -LIM_ONE, LIM_ONE);
      m_last_elec = elec[ELEC_W-1:0];
      m_last_speed = spd[SPEED_W-1:0];
      word.raw_angle = raw;
      word.mech_angle = mech[MECH_W-1:0];
      word.elec_angle = elec[ELEC_W-1:0];
      word.speed = spd[SPEED_W-1:0];
      word.direction_out = dir;
      return word;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
      end
   endtask

   task automatic check_word();
      angle_word_type want;
      if (pending_angles.size() == 0) begin
         report_mismatch("word with nothing pending", 64'(rsp_bus.raw_angle), 64'd0);
         return;
      end
      want = pending_angles.pop_front();
      if (rsp_bus.raw_angle !== want.raw_angle) begin
         report_mismatch("raw_angle", 64'(rsp_bus.raw_angle), 64'(want.raw_angle));
      end
      if (rsp_bus.mech_angle !== want.mech_angle) begin
         report_mismatch("mech_angle", 64'(rsp_bus.mech_angle), 64'(want.mech_angle));
      end
      if (rsp_bus.elec_angle !== want.elec_angle) begin
         report_mismatch("elec_angle", 64'(rsp_bus.elec_angle), 64'(want.elec_angle));
      end
      if (rsp_bus.speed !== want.speed) begin
         report_mismatch("speed", 64'(rsp_bus.speed), 64'(want.speed));
      end
      if (rsp_bus.direction_out !== want.direction_out) begin
         report_mismatch("direction_out", 64'(rsp_bus.direction_out),
                         64'(want.direction_out));
      end
   endtask

   // Result side: checks every accepted word and paces ready, with an
   // occasional long hold-off requested by a test.
   initial begin : word_sink
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_word();
         end
         if (stall_asks != stall_seen) begin
            stall_seen = stall_asks;
            stall_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 24);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_encoder_angle_speed_estimator: errors");
      $finish;
   end

   // Valid is left high after acceptance so that back-to-back samples need no
   // gap; anything that stops sending goes through wait_drain, which lowers it.
   task automatic send_sample(input logic [POS_W-1:0] pos,
                              input logic signed [DIR_W-1:0] dir);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.position_count <= pos;
      req_bus.direction <= dir;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_angles.push_back(estimate_angles(pos, dir));
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (pending_angles.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_CAL_OFFSET:  m_cal_offset = value[POS_W-1:0];
         CSR_COUNT_SCALE: m_count_scale = value;
         CSR_POLE_PAIRS:  m_pole_pairs = value[PPC_W-1:0];
         CSR_SPEED_GAIN:  m_speed_gain = value;
         CSR_FILTER_KEEP: m_filter_keep = value[FW_W-1:0];
         CSR_FILTER_TAKE: m_filter_take = value[FW_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Flags shared with the result side change between edges only.
   task automatic pace(input bit steady, input bit hold_rsp);
      @(negedge clock);
      no_idle = steady;
      if (hold_rsp) begin
         stall_asks++;
      end
      @(posedge clock);
   endtask

   task automatic random_setup(input bit wild);
      logic [POS_W-1:0] cal;
      int raw_top;
      longint cpr;
      logic signed [31:0] scale, gain;
      logic [PPC_W-1:0] pole;
      logic [FW_W-1:0] keep, take;
      cal = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
      // Roughly one revolution over the reachable counts keeps many samples in band.
      raw_top = int'(cal) + 65535;
      cpr = $urandom_range(raw_top / 2, raw_top * 2);
      scale = 32'((longint'(1) << 30) / cpr);
      if ($urandom_range(1) == 1) begin
         scale = -scale;
      end
      pole = 7'($urandom_range(1, 64));
      gain = 32'($urandom_range(0, 32'h1000_0000));
      if ($urandom_range(1) == 1) begin
         gain = -gain;
      end
      take = 25'($urandom_range(0, 32'd16777216));
      keep = 25'd16777216 - take;
      if (wild) begin
         scale = $urandom;
         gain = $urandom;
         pole = 7'($urandom);
         keep = 25'($urandom);
         take = 25'($urandom);
      end
      wait_drain();
      write_reg(CSR_CAL_OFFSET, {16'($urandom), cal});
      write_reg(CSR_COUNT_SCALE, scale);
      write_reg(CSR_POLE_PAIRS, {25'($urandom), pole});
      write_reg(CSR_SPEED_GAIN, gain);
      write_reg(CSR_FILTER_KEEP, {7'($urandom), keep});
      write_reg(CSR_FILTER_TAKE, {7'($urandom), take});
   endtask

   // Mostly a turning shaft: runs of steadily stepping counts, with some
   // runs of unrelated counts and directions mixed in.
   task automatic run_motion(input int count);
      logic [POS_W-1:0] pos;
      logic signed [DIR_W-1:0] dir;
      int step;
      int left;
      bit noisy;
      left = 0;
      step = 0;
      noisy = 1'b0;
      pos = 16'($urandom);
      repeat (count) begin
         if (left == 0) begin
            left = $urandom_range(8, 40);
            noisy = ($urandom_range(4) == 0);
            step = int'($urandom_range(400)) - 200;
            pos = 16'($urandom);
         end
         left--;
         if (noisy) begin
            pos = 16'($urandom);
            dir = 2'($urandom);
         end else begin
            pos = pos + 16'(step + int'($urandom_range(6)) - 3);
            dir = (step < 0) ? DIR_REV : DIR_FWD;
         end
         if ($urandom_range(99) == 0) begin
            wait_drain();
         end
         send_sample(pos, dir);
      end
   endtask

   task automatic test_reset_values();
      send_sample(16'd0, DIR_FWD);
      send_sample(16'd1000, DIR_FWD);
      send_sample(16'd2000, DIR_FWD);
      send_sample(16'd3000, DIR_REV);
   endtask

   task automatic test_field_extremes();
      wait_drain();
      write_reg(CSR_CAL_OFFSET, 32'h0000_FFFF);
      send_sample(16'hFFFF, DIR_ODD);
      send_sample(16'h0000, DIR_ZERO);
      send_sample(16'hAAAA, DIR_REV);
      send_sample(16'h5555, DIR_FWD);
      wait_drain();
      write_reg(CSR_CAL_OFFSET, 32'd0);
   endtask

   // A scale of 64 times k puts the mechanical angle of count one at exactly k.
   task automatic test_band_edges();
      int band_mags [4];
      int k;
      int sgn;
      band_mags = '{int'(BAND_LOW) - 1, int'(BAND_LOW), int'(BAND_HIGH),
                    int'(BAND_HIGH) + 1};
      for (k = 0; k < 4; k++) begin
         for (sgn = 0; sgn < 2; sgn++) begin
            wait_drain();
            write_reg(CSR_COUNT_SCALE, (sgn != 0) ? -(64 * band_mags[k]) : 64 * band_mags[k]);
            send_sample(16'd1, (sgn != 0) ? DIR_REV : DIR_FWD);
         end
      end
   endtask

   // Saturated angles followed by an in-band sample force a huge angle step,
   // so the raw speed saturates and the filter output hits its clamp.
   task automatic test_saturation();
      wait_drain();
      write_reg(CSR_POLE_PAIRS, ALL_ONES);
      write_reg(CSR_SPEED_GAIN, S32_MAX);
      write_reg(CSR_FILTER_KEEP, ALL_ONES);
      write_reg(CSR_FILTER_TAKE, ALL_ONES);
      write_reg(CSR_COUNT_SCALE, S32_MAX);
      send_sample(16'hFFFF, DIR_FWD);
      wait_drain();
      write_reg(CSR_COUNT_SCALE, HALF_REV_SCALE);
      send_sample(16'd1, DIR_FWD);
      wait_drain();
      write_reg(CSR_COUNT_SCALE, S32_MIN);
      write_reg(CSR_SPEED_GAIN, S32_MIN);
      send_sample(16'hFFFF, DIR_REV);
      wait_drain();
      write_reg(CSR_COUNT_SCALE, NHALF_REV_SCALE);
      send_sample(16'd1, DIR_REV);
      wait_drain();
      write_reg(CSR_POLE_PAIRS, 32'd0);
      send_sample(16'd1, DIR_FWD);
      wait_drain();
      write_reg(CSR_CAL_OFFSET, CSR_DATA_W'(RST_CAL_OFFSET));
      write_reg(CSR_COUNT_SCALE, RST_COUNT_SCALE);
      write_reg(CSR_POLE_PAIRS, CSR_DATA_W'(RST_POLE_PAIRS));
      write_reg(CSR_SPEED_GAIN, RST_SPEED_GAIN);
      write_reg(CSR_FILTER_KEEP, CSR_DATA_W'(RST_FILTER_KEEP));
      write_reg(CSR_FILTER_TAKE, CSR_DATA_W'(RST_FILTER_TAKE));
   endtask

   task automatic test_unknown_index();
      wait_drain();
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
      send_sample(16'd2500, DIR_FWD);
      send_sample(16'd3500, DIR_FWD);
   endtask

   // The result side holds off while samples keep coming, so the block fills
   // up and has to stall its input.
   task automatic test_backpressure();
      wait_drain();
      pace(1'b1, 1'b1);
      run_motion(60);
      wait_drain();
      pace(1'b0, 1'b0);
   endtask

   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < 12; phase++) begin
         random_setup(phase == 3 || phase == 9);
         wait_drain();
         pace(phase == 5, 1'b0);
         run_motion(102);
      end
      wait_drain();
      pace(1'b0, 1'b0);
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.position_count <= '0;
      req_bus.direction <= DIR_ZERO;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_CAL_OFFSET;
      csr_bus.data <= '0;
      error_count = 0;
      no_idle = 1'b0;
      stall_asks = 0;
      stall_seen = 0;
      stall_left = 0;
      m_cal_offset = RST_CAL_OFFSET;
      m_count_scale = RST_COUNT_SCALE;
      m_pole_pairs = RST_POLE_PAIRS;
      m_speed_gain = RST_SPEED_GAIN;
      m_filter_keep = RST_FILTER_KEEP;
      m_filter_take = RST_FILTER_TAKE;
      m_last_elec = '0;
      m_last_speed = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_extremes();
      test_band_edges();
      test_saturation();
      test_unknown_index();
      test_backpressure();
      test_random_phases();
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_encoder_angle_speed_estimator: clean");
      end else begin
         $display("tb_encoder_angle_speed_estimator: errors");
      end
      $finish;
   end

endmodule
